@@ sv/armt_pkg.sv @@
// ----------------------------------------------------------------------------
// armt_pkg
// Shared types and constants of the address region map table.
// ----------------------------------------------------------------------------
package armt_pkg;

	localparam int MAX_REGIONS = 16;
	localparam int PAGE_BITS   = 12;
	localparam int IW          = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int CW          = $clog2(MAX_REGIONS + 1);

	localparam logic [32:0] PG_MASK = (33'd1 << PAGE_BITS) - 33'd1;

	localparam logic [1:0] CMD_MAP   = 2'd0;
	localparam logic [1:0] CMD_UNMAP = 2'd1;
	localparam logic [1:0] CMD_FIND  = 2'd2;
	localparam logic [1:0] CMD_RSVD  = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FAIL = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] size;
		logic [7:0]  prot;
	} entry_t;

	typedef enum logic [1:0] {
		TB_NOP,
		TB_WRITE,
		TB_REMOVE,
		TB_INSERT
	} tb_op_t;

	// edit request from the sequencer to the region table
	typedef struct packed {
		tb_op_t          op;
		logic [IW-1:0]   idx;
		entry_t          ent;
	} tb_cmd_t;

endpackage

@@ sv/armt_req_if.sv @@
// ----------------------------------------------------------------------------
// armt_req_if
// Command channel of the region map table: valid, ready and one command word.
// ----------------------------------------------------------------------------
interface armt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] req_addr;
	logic [31:0] req_size;
	logic [7:0]  req_prot;

	modport source (output valid, cmd, req_addr, req_size, req_prot, input ready);
	modport sink (input valid, cmd, req_addr, req_size, req_prot, output ready);
endinterface

@@ sv/armt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// armt_rsp_if
// Result channel of the region map table: valid, ready and one result word.
// ----------------------------------------------------------------------------
interface armt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] mapped_addr;
	logic [31:0] region_base;
	logic [31:0] region_size;
	logic [7:0]  region_prot;

	modport source (output valid, status, mapped_addr, region_base, region_size,
		region_prot, input ready);
	modport sink (input valid, status, mapped_addr, region_base, region_size,
		region_prot, output ready);
endinterface

@@ sv/address_region_map_table.sv @@
// ----------------------------------------------------------------------------
// address_region_map_table
// Map, unmap and find over a sorted table of page-rounded address regions.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | word
//  req     | in  | valid / ready | cmd, req_addr, req_size, req_prot
//  rsp     | out | valid / ready | status, mapped_addr, region_base/size/prot
//  cfg     | in  | cfg_we        | cfg_wdata -> min_map_addr
//
// One command at a time; a sequencer walks the table one entry per cycle.
// Map runs a placement scan, an overlap scan, merge reads and a commit;
// unmap and find each run one scan of the table.
// Reset empties the table at once and sets min_map_addr to 4096.
// A result waits in the output register; the next command is taken while
// it waits, and the sequencer stalls only to hand over a second result.
// ----------------------------------------------------------------------------
module address_region_map_table (
	input  logic        clk,
	input  logic        arst_n,
	armt_req_if.sink    req,
	armt_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);
	import armt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PLACE, S_CHECK, S_OVL, S_PREV, S_NEXT, S_COMMIT, S_REMOVE,
		S_USCAN, S_USPLIT, S_FSCAN, S_FCHECK, S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] maddr;
		entry_t      reg_ent;
	} res_t;

	state_t        state_q;
	logic [31:0]   min_q;
	logic [31:0]   addr_q, size_q;
	logic [7:0]    prot_q;
	logic [32:0]   a_q, n_q, t_q, e_q;
	logic [31:0]   s_q;
	logic [CW-1:0] i_q, p_q;
	logic          mp_q, mn_q, hit_q;
	entry_t        prev_q;
	logic [31:0]   nsize_q;
	res_t          res_q, out_q;
	logic          ov_q;

	entry_t        rd;
	logic [CW-1:0] cnt;
	tb_cmd_t       tcmd;

	armt_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.tcmd   (tcmd),
		.rd_idx (i_q[IW-1:0]),
		.rd_ent (rd),
		.cnt    (cnt)
	);

	// shared compare terms on the entry under the scan index
	logic [32:0] rd_b, rd_end;
	logic [33:0] a_end, p_sum;
	logic [33:0] base_sz;
	logic [34:0] n_sum;
	logic        in_range, tbl_full, u_keep, u_lo, u_hi;
	logic [32:0] in_s, in_n, auto_a, auto_n;
	logic        acc, slot_free;
	logic [31:0] mp_new;

	assign rd_b     = {1'b0, rd.base};
	assign rd_end   = {1'b0, rd.base} + {1'b0, rd.size};
	assign a_end    = {1'b0, a_q} + {1'b0, n_q};
	assign p_sum    = {2'b0, rd.size} + {1'b0, n_q};
	assign base_sz  = mp_q ? ({2'b0, prev_q.size} + {1'b0, n_q}) : {1'b0, n_q};
	assign n_sum    = {1'b0, base_sz} + {3'b0, rd.size};
	assign in_range = i_q < cnt;
	assign tbl_full = cnt >= CW'(MAX_REGIONS);
	assign u_keep   = (rd_end <= {1'b0, s_q}) || (rd_b >= t_q);
	assign u_lo     = rd_b < {1'b0, s_q};
	assign u_hi     = rd_end > t_q;
	assign mp_new   = prev_q.size + n_q[31:0] + (mn_q ? nsize_q : 32'd0);

	// page rounding of the incoming range
	assign in_s   = {1'b0, req.req_addr} & ~PG_MASK;
	assign in_n   = (({1'b0, req.req_addr} & PG_MASK) + {1'b0, req.req_size} + PG_MASK)
		& ~PG_MASK;
	assign auto_a = ({1'b0, min_q} + PG_MASK) & ~PG_MASK;
	assign auto_n = ({1'b0, req.req_size} + PG_MASK) & ~PG_MASK;

	assign acc       = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign slot_free = !ov_q || rsp.ready;

	// table edits issued by the sequencer
	always_comb begin
		tcmd     = '0;
		tcmd.op  = TB_NOP;
		tcmd.idx = i_q[IW-1:0];
		tcmd.ent = rd;
		unique case (state_q)
			S_COMMIT: begin
				if (mp_q) begin
					tcmd.op  = TB_WRITE;
					tcmd.idx = IW'(p_q - CW'(1));
					tcmd.ent = '{base: prev_q.base, size: mp_new, prot: prev_q.prot};
				end else if (mn_q) begin
					tcmd.op  = TB_WRITE;
					tcmd.idx = p_q[IW-1:0];
					tcmd.ent = '{base: a_q[31:0], size: nsize_q + n_q[31:0], prot: prot_q};
				end else if (!tbl_full) begin
					tcmd.op  = TB_INSERT;
					tcmd.idx = p_q[IW-1:0];
					tcmd.ent = '{base: a_q[31:0], size: n_q[31:0], prot: prot_q};
				end
			end
			S_REMOVE: begin
				tcmd.op  = TB_REMOVE;
				tcmd.idx = p_q[IW-1:0];
			end
			S_USCAN: begin
				if (in_range && !u_keep) begin
					if (u_lo && u_hi) begin
						if (!tbl_full) begin
							tcmd.op       = TB_WRITE;
							tcmd.ent.size = s_q - rd.base;
						end
					end else if (u_lo) begin
						tcmd.op       = TB_WRITE;
						tcmd.ent.size = s_q - rd.base;
					end else if (u_hi) begin
						tcmd.op       = TB_WRITE;
						tcmd.ent.base = t_q[31:0];
						tcmd.ent.size = rd_end[31:0] - t_q[31:0];
					end else begin
						tcmd.op = TB_REMOVE;
					end
				end
			end
			S_USPLIT: begin
				tcmd.op  = TB_INSERT;
				tcmd.idx = IW'(i_q + CW'(1));
				tcmd.ent = '{base: t_q[31:0], size: e_q[31:0] - t_q[31:0],
					prot: prev_q.prot};
			end
			default: begin
			end
		endcase
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			min_q   <= 32'd4096;
			ov_q    <= 1'b0;
			i_q     <= '0;
			p_q     <= '0;
			mp_q    <= 1'b0;
			mn_q    <= 1'b0;
			hit_q   <= 1'b0;
			addr_q  <= '0;
			size_q  <= '0;
			prot_q  <= '0;
			a_q     <= '0;
			n_q     <= '0;
			t_q     <= '0;
			e_q     <= '0;
			s_q     <= '0;
			prev_q  <= '0;
			nsize_q <= '0;
			res_q   <= '0;
			out_q   <= '0;
		end else begin
			if (cfg_we) min_q <= cfg_wdata;
			// drop the held word once taken, unless a new one replaces it
			if (ov_q && rsp.ready && state_q != S_DONE) ov_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						addr_q <= req.req_addr;
						size_q <= req.req_size;
						prot_q <= req.req_prot;
						i_q    <= '0;
						hit_q  <= 1'b0;
						case (req.cmd)
							CMD_MAP: begin
								res_q <= '0;
								if (req.req_addr == 32'd0) begin
									a_q     <= auto_a;
									n_q     <= auto_n;
									state_q <= S_PLACE;
								end else begin
									a_q     <= in_s;
									n_q     <= in_n;
									state_q <= S_CHECK;
								end
							end
							CMD_UNMAP: begin
								res_q <= '0;
								s_q <= in_s[31:0];
								t_q <= (({1'b0, in_s} + {1'b0, in_n}) > 34'h1_0000_0000)
									? 33'h1_0000_0000 : 33'(in_s + in_n);
								state_q <= (in_n == 33'd0) ? S_DONE : S_USCAN;
							end
							CMD_FIND: begin
								res_q   <= '0;
								state_q <= S_FSCAN;
							end
							default: begin
								res_q   <= '{status: ST_FAIL, maddr: 32'd0, reg_ent: '0};
								state_q <= S_DONE;
							end
						endcase
					end
				end
				// first-fit: hop past every region that meets the candidate
				S_PLACE: begin
					if (!in_range) begin
						state_q <= S_CHECK;
					end else if (rd_end <= a_q) begin
						i_q <= i_q + CW'(1);
					end else if ({1'b0, rd_b} >= a_end) begin
						state_q <= S_CHECK;
					end else begin
						a_q <= rd_end;
						i_q <= i_q + CW'(1);
					end
				end
				S_CHECK: begin
					if (n_q == 33'd0 || n_q[32] || a_end > 34'h1_0000_0000 ||
						a_q < {1'b0, min_q}) begin
						res_q.status <= ST_FAIL;
						state_q      <= S_DONE;
					end else begin
						i_q     <= '0;
						p_q     <= '0;
						state_q <= S_OVL;
					end
				end
				// reject overlap; count entries below the new base
				S_OVL: begin
					if (!in_range) begin
						mp_q <= 1'b0;
						if (p_q != '0) begin
							i_q     <= p_q - CW'(1);
							state_q <= S_PREV;
						end else begin
							i_q     <= p_q;
							state_q <= S_NEXT;
						end
					end else if ({1'b0, rd_b} < a_end && rd_end > a_q) begin
						res_q.status <= ST_FAIL;
						state_q      <= S_DONE;
					end else begin
						if (rd_b < a_q) p_q <= i_q + CW'(1);
						i_q <= i_q + CW'(1);
					end
				end
				S_PREV: begin
					prev_q  <= rd;
					mp_q    <= (rd_end == a_q) && (rd.prot == prot_q) &&
						(p_sum <= 34'hFFFF_FFFF);
					i_q     <= p_q;
					state_q <= S_NEXT;
				end
				S_NEXT: begin
					nsize_q <= rd.size;
					mn_q    <= (p_q < cnt) && ({1'b0, rd_b} == a_end) &&
						(rd.prot == prot_q) && (n_sum <= 35'hFFFF_FFFF);
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					state_q <= S_DONE;
					if (mp_q) begin
						res_q <= '{status: ST_OK, maddr: a_q[31:0],
							reg_ent: '{base: prev_q.base, size: mp_new, prot: prev_q.prot}};
						if (mn_q) state_q <= S_REMOVE;
					end else if (mn_q) begin
						res_q <= '{status: ST_OK, maddr: a_q[31:0],
							reg_ent: '{base: a_q[31:0], size: nsize_q + n_q[31:0],
							prot: prot_q}};
					end else if (tbl_full) begin
						res_q.status <= ST_FULL;
					end else begin
						res_q <= '{status: ST_OK, maddr: a_q[31:0],
							reg_ent: '{base: a_q[31:0], size: n_q[31:0], prot: prot_q}};
					end
				end
				S_REMOVE: begin
					state_q <= S_DONE;
				end
				// trim, drop or split each region that meets the range
				S_USCAN: begin
					if (!in_range) begin
						state_q <= S_DONE;
					end else if (u_keep) begin
						i_q <= i_q + CW'(1);
					end else if (u_lo && u_hi) begin
						if (tbl_full) begin
							res_q.status <= ST_FULL;
							state_q      <= S_DONE;
						end else begin
							e_q     <= rd_end;
							prev_q  <= rd;
							state_q <= S_USPLIT;
						end
					end else if (u_lo || u_hi) begin
						i_q <= i_q + CW'(1);
					end
				end
				S_USPLIT: begin
					state_q <= S_DONE;
				end
				// hold the last region whose base is not above the address
				S_FSCAN: begin
					if (!in_range || rd.base > addr_q) begin
						state_q <= S_FCHECK;
					end else begin
						prev_q <= rd;
						hit_q  <= 1'b1;
						i_q    <= i_q + CW'(1);
					end
				end
				S_FCHECK: begin
					if (hit_q && ({1'b0, addr_q} + {1'b0, size_q}) <=
						({1'b0, prev_q.base} + {1'b0, prev_q.size})) begin
						res_q <= '{status: ST_OK, maddr: 32'd0, reg_ent: prev_q};
					end else begin
						res_q.status <= ST_FAIL;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (slot_free) begin
						out_q   <= res_q;
						ov_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = ov_q;
	assign rsp.status      = out_q.status;
	assign rsp.mapped_addr = out_q.maddr;
	assign rsp.region_base = out_q.reg_ent.base;
	assign rsp.region_size = out_q.reg_ent.size;
	assign rsp.region_prot = out_q.reg_ent.prot;

	// table never holds more entries than it has room for
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt <= CW'(MAX_REGIONS))
		else $error("region count overflow");

	// an insert is never issued into a full table
	a_ins: assert property (@(posedge clk) disable iff (!arst_n)
		tcmd.op == TB_INSERT |-> !tbl_full)
		else $error("insert into full table");

	// a taken command keeps ready low in the following cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !req.ready)
		else $error("command taken while busy");

	// status code 3 never leaves the block
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.status == ST_OK || rsp.status == ST_FAIL ||
		rsp.status == ST_FULL))
		else $error("bad status");

endmodule

@@ sv/armt_table.sv @@
// ----------------------------------------------------------------------------
// armt_table
// Sorted region store: one read port, and one edit per cycle (write an
// entry, remove an entry with shift down, insert an entry with shift up).
// ----------------------------------------------------------------------------
module armt_table (
	input  logic                    clk,
	input  logic                    arst_n,
	input  armt_pkg::tb_cmd_t       tcmd,
	input  logic [armt_pkg::IW-1:0] rd_idx,
	output armt_pkg::entry_t        rd_ent,
	output logic [armt_pkg::CW-1:0] cnt
);
	import armt_pkg::*;

	entry_t        ent_q [MAX_REGIONS];
	logic [CW-1:0] cnt_q;

	assign rd_ent = ent_q[rd_idx];
	assign cnt    = cnt_q;

	// track the number of live entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (tcmd.op)
				TB_REMOVE: cnt_q <= cnt_q - CW'(1);
				TB_INSERT: cnt_q <= cnt_q + CW'(1);
				default:   cnt_q <= cnt_q;
			endcase
		end
	end

	// apply the edit, shifting neighbors as needed
	always_ff @(posedge clk) begin
		case (tcmd.op)
			TB_WRITE: begin
				ent_q[tcmd.idx] <= tcmd.ent;
			end
			TB_REMOVE: begin
				for (int j = 0; j < MAX_REGIONS - 1; j++) begin
					if (IW'(j) >= tcmd.idx) ent_q[j] <= ent_q[j + 1];
				end
			end
			TB_INSERT: begin
				for (int j = 1; j < MAX_REGIONS; j++) begin
					if (IW'(j) > tcmd.idx) ent_q[j] <= ent_q[j - 1];
				end
				ent_q[tcmd.idx] <= tcmd.ent;
			end
			default: begin
			end
		endcase
	end

endmodule
